/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on clock; PBD_ASSERT holds off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset.
`define PBD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
// Checked on every rising edge, reset included.
`define PBD_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("assertion failed");
`else
`define PBD_ASSERT(lbl, prop)
`define PBD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* design/pbd_pkg.sv */
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared widths, register codes and control types of the burst detector.
// ----------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

   localparam int KEY_W          = 6;
   localparam int FRAME_IN_W     = 32;
   localparam int WINDOW_W       = 16;
   localparam int THRESH_W       = 4;
   localparam int COUNT_W        = 4;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;

   localparam int NUM_KEYS_DEF   = 64;
   localparam int FRAME_BITS_DEF = 32;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(600);
   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW    = 2'd0,
      CSR_THRESHOLD = 2'd1
   } pbd_csr_index_type;

   // What the update stage does with one item.
   typedef struct packed {
      logic extend;     // event joins the open run
      logic count_up;   // run count increments
      logic report;     // count just reached the threshold
      logic start_run;  // fresh run of one
   } pbd_decision_type;

endpackage

`default_nettype wire

/* design/pbd_intf.sv */
// ----------------------------------------------------------------------------
// pbd_intf
// Valid/ready channels of the burst detector: events, incidents, registers.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbd_req_if import pbd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  batch_start;
   logic [KEY_W-1:0]      key_index;
   logic [FRAME_IN_W-1:0] frame_number;

   modport source (output valid, batch_start, key_index, frame_number, input ready);
   modport sink   (input valid, batch_start, key_index, frame_number, output ready);
endinterface

interface pbd_rsp_if import pbd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [KEY_W-1:0]      incident_key;
   logic [FRAME_IN_W-1:0] incident_first_frame;

   modport source (output valid, incident_key, incident_first_frame, input ready);
   modport sink   (input valid, incident_key, incident_first_frame, output ready);
endinterface

interface pbd_csr_if import pbd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/pbd_run_table.sv */
// ----------------------------------------------------------------------------
// pbd_run_table
// Per-key run memory (first frame, last frame, count) with registered read
// and write-to-read forwarding for back-to-back items on one key.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_run_table
   import pbd_pkg::*;
#(
   parameter int NUM_KEYS   = NUM_KEYS_DEF,
   parameter int FRAME_BITS = FRAME_BITS_DEF,
   localparam int KEY_BITS  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [KEY_BITS-1:0]   rd_key,
   input  wire logic                  wr_en,
   input  wire logic [KEY_BITS-1:0]   wr_key,
   input  wire logic [FRAME_BITS-1:0] wr_first,
   input  wire logic [FRAME_BITS-1:0] wr_last,
   input  wire logic [COUNT_W-1:0]    wr_count,
   output logic      [FRAME_BITS-1:0] rd_first,
   output logic      [FRAME_BITS-1:0] rd_last,
   output logic      [COUNT_W-1:0]    rd_count
);

   localparam int ENTRY_W = 2 * FRAME_BITS + COUNT_W;

   logic [ENTRY_W-1:0] mem [NUM_KEYS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ENTRY_W-1:0] fwd_data_ff;
   logic               fwd_ff;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] entry;
   logic               fwd_in;

   assign wr_data = {wr_first, wr_last, wr_count};
   // a write on the same edge as the read would be missed by the array read
   assign fwd_in  = wr_en && (wr_key == rd_key);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_key] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_key];
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr_data;
      end
   end

   assign entry    = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign rd_first = entry[ENTRY_W-1 -: FRAME_BITS];
   assign rd_last  = entry[COUNT_W +: FRAME_BITS];
   assign rd_count = entry[COUNT_W-1:0];

endmodule

`default_nettype wire

/* design/pbd_run_eval.sv */
// ----------------------------------------------------------------------------
// pbd_run_eval
// Decides per event whether it extends the key's run, counts up, reports,
// or starts a new run.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_run_eval
   import pbd_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEF
) (
   input  wire logic                  in_range,
   input  wire logic                  run_valid,
   input  wire logic [FRAME_BITS-1:0] frame,
   input  wire logic [FRAME_BITS-1:0] last_frame,
   input  wire logic [COUNT_W-1:0]    count,
   input  wire logic [WINDOW_W-1:0]   window,
   input  wire logic [THRESH_W-1:0]   threshold,
   output pbd_decision_type           decision,
   output logic      [COUNT_W-1:0]    count_next
);

   logic [FRAME_BITS-1:0] gap;
   logic                  close;
   logic [COUNT_W-1:0]    count_inc;

   // wrapped gap read as two's complement; negative always counts as close
   assign gap   = frame - last_frame;
   assign close = gap[FRAME_BITS-1] || (gap < FRAME_BITS'(window));

   assign count_inc = count + COUNT_W'(1);

   always_comb begin
      decision.extend    = in_range && run_valid && close;
      decision.start_run = in_range && !decision.extend;
      decision.count_up  = decision.extend && (COUNT_W'(count) < COUNT_W'(threshold));
      decision.report    = decision.count_up && (count_inc == COUNT_W'(threshold));
      if (decision.start_run) begin
         count_next = COUNT_W'(1);
      end else if (decision.count_up) begin
         count_next = count_inc;
      end else begin
         count_next = count;
      end
   end

endmodule

`default_nettype wire

/* design/per_key_event_burst_detector.sv */
// ----------------------------------------------------------------------------
// per_key_event_burst_detector
// Tracks a run of close events per key and reports key and first frame once
// when a run's count reaches the threshold.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | handshake
//  req_bus  | in  | batch_start, key_index, frame_number      | valid/ready
//  rsp_bus  | out | incident_key, incident_first_frame        | valid/ready
//  csr_bus  | in  | index (0 window, 1 threshold), data       | valid/ready
//
//  One item per cycle unless a held incident stalls; an incident passes the
//  update stage, then the result register. The run table is read at accept
//  and written at commit; a forward path covers back-to-back items on one key.
//  Reset clears all valid marks at once; no clearing pass. csr is always ready.
//  A held incident stalls the update stage only while it is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module per_key_event_burst_detector
   import pbd_pkg::*;
#(
   parameter int NUM_KEYS   = NUM_KEYS_DEF,
   parameter int FRAME_BITS = FRAME_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   pbd_req_if.sink   req_bus,
   pbd_rsp_if.source rsp_bus,
   pbd_csr_if.sink   csr_bus
);

`include "assert_macros.svh"

   localparam int KEY_BITS = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CMP_W    = KEY_W + 9;

   // configuration
   logic [WINDOW_W-1:0] window_ff;
   logic [THRESH_W-1:0] thresh_ff;

   // update stage
   logic                  s1_valid_ff;
   logic                  s1_batch_ff;
   logic                  s1_in_range_ff;
   logic [KEY_BITS-1:0]   s1_key_ff;
   logic [FRAME_BITS-1:0] s1_frame_ff;

   logic [NUM_KEYS-1:0]   valid_ff;
   logic [NUM_KEYS-1:0]   valid_in;

   // result register
   logic                  rsp_valid_ff;
   logic [KEY_W-1:0]      rsp_key_ff;
   logic [FRAME_IN_W-1:0] rsp_first_ff;

   logic                  advance;
   logic                  commit;
   logic                  req_accept;
   logic                  req_in_range;
   logic [KEY_BITS-1:0]   req_key;
   logic                  run_valid;

   logic [FRAME_BITS-1:0] rd_first;
   logic [FRAME_BITS-1:0] rd_last;
   logic [COUNT_W-1:0]    rd_count;
   logic [COUNT_W-1:0]    count_next;
   pbd_decision_type      decision;
   logic                  tbl_wr_en;
   logic [FRAME_BITS-1:0] wr_first;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_WINDOW:    window_ff <= WINDOW_W'(csr_bus.data);
            CSR_THRESHOLD: thresh_ff <= THRESH_W'(csr_bus.data);
            default: ;
         endcase
      end
   end

   // handshake: update stage moves whenever the result register can take
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign commit        = s1_valid_ff && advance;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign req_in_range = CMP_W'(req_bus.key_index) < CMP_W'(NUM_KEYS);
   assign req_key      = KEY_BITS'(req_bus.key_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_batch_ff    <= req_bus.batch_start;
         s1_in_range_ff <= req_in_range;
         s1_key_ff      <= req_key;
         s1_frame_ff    <= FRAME_BITS'(req_bus.frame_number);
      end
   end

   assign tbl_wr_en = commit && s1_in_range_ff;
   assign wr_first  = decision.start_run ? s1_frame_ff : rd_first;

   pbd_run_table #(
      .NUM_KEYS   (NUM_KEYS),
      .FRAME_BITS (FRAME_BITS)
   ) u_table (
      .clock    (clock),
      .rd_en    (req_accept && req_in_range),
      .rd_key   (req_key),
      .wr_en    (tbl_wr_en),
      .wr_key   (s1_key_ff),
      .wr_first (wr_first),
      .wr_last  (s1_frame_ff),
      .wr_count (count_next),
      .rd_first (rd_first),
      .rd_last  (rd_last),
      .rd_count (rd_count)
   );

   // batch start drops every run before this event is looked at
   assign run_valid = s1_in_range_ff && !s1_batch_ff && valid_ff[s1_key_ff];

   pbd_run_eval #(
      .FRAME_BITS (FRAME_BITS)
   ) u_eval (
      .in_range   (s1_in_range_ff),
      .run_valid  (run_valid),
      .frame      (s1_frame_ff),
      .last_frame (rd_last),
      .count      (rd_count),
      .window     (window_ff),
      .threshold  (thresh_ff),
      .decision   (decision),
      .count_next (count_next)
   );

   always_comb begin
      valid_in = s1_batch_ff ? '0 : valid_ff;
      if (decision.start_run) begin
         valid_in[s1_key_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (commit) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit && decision.report) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && decision.report) begin
         rsp_key_ff   <= KEY_W'(s1_key_ff);
         rsp_first_ff <= FRAME_IN_W'(rd_first);
      end
   end

   assign rsp_bus.valid                = rsp_valid_ff;
   assign rsp_bus.incident_key         = rsp_key_ff;
   assign rsp_bus.incident_first_frame = rsp_first_ff;

   // a stalled update stage must not be overwritten by a new item
   `PBD_ASSERT(a_no_overrun, (s1_valid_ff && !advance) |-> !req_accept)
   // an incident only appears after a committed report
   `PBD_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(commit && decision.report))
   // a report only comes out of a valid run extended up to the threshold
   `PBD_ASSERT(a_report_count,
      (commit && decision.report) |-> (decision.extend && count_next == COUNT_W'(thresh_ff)))
   // a new run and an extension never happen together
   `PBD_ASSERT(a_decision_excl, s1_valid_ff |-> !(decision.extend && decision.start_run))

endmodule

`default_nettype wire
